// ----- sv/scc_pkg.sv -----
// Package for the segment CRC compare checker.
// Holds the item structs, operation and status codes, CRC and sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package scc_pkg;

    // Operation codes of an input item.
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_PAIR  = 1'b1;

    // Status codes of a result item.
    localparam logic [1:0] STATUS_MATCH     = 2'd0;
    localparam logic [1:0] STATUS_CORRUPTED = 2'd1;
    localparam logic [1:0] STATUS_SKIPPED   = 2'd2;
    localparam logic [1:0] STATUS_UNREAD    = 2'd3;

    // Reflected CRC-32 constants.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Sampling limits on the segment length.
    localparam logic [31:0] FULL_LIMIT = 32'd262144;
    localparam logic [31:0] HALF_LIMIT = 32'd1048576;
    // Bits that hold a length up to FULL_LIMIT, and any halved size.
    localparam int          FULL_W     = 19;

    // Division by one hundred: q = (len * DIV100_MUL) >> DIV100_SHIFT, exact for 32 bits.
    localparam logic [31:0] DIV100_MUL   = 32'h51EB_851F;
    localparam int          DIV100_SHIFT = 37;
    localparam int          QUOT_W       = 64 - DIV100_SHIFT;

    // One input item.
    typedef struct packed {
        logic        operation;
        logic [31:0] seg_offset;
        logic [31:0] seg_length;
        logic [7:0]  host_byte;
        logic [7:0]  device_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] host_crc;
        logic [31:0] device_crc;
    } t_out_item;

endpackage

// ----- sv/scc_crc8.sv -----
// One byte of reflected CRC-32 update, unrolled over the eight bit steps.
// Depends on scc_pkg for the polynomial.
`timescale 1ns / 1ps

module scc_crc8
    import scc_pkg::*;
(
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    // Fold the byte in, then shift out eight bits, adding the polynomial on a one.
    always_comb begin
        logic [31:0] acc;
        acc = i_crc ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            acc = (acc >> 1) ^ (acc[0] ? CRC_POLY : 32'd0);
        end
        o_crc = acc;
    end

endmodule

// ----- sv/segment_crc_compare_checker_top.sv -----
// Top level of the segment CRC compare checker.
// Depends on scc_pkg and scc_crc8.
//
// Usage:
//   A begin item carries a segment offset and length. The block derives a
//   sampled check size from the length and tests offset plus size against
//   the image size register. Out of range gives a skipped result at once,
//   an empty size gives a match at once; otherwise the following byte-pair
//   items are folded into a host and a device CRC-32, and the last pair of
//   the segment gives a match, corrupted or unread result.
//   Input items and result items use valid/ready; the image size register
//   is written through its own valid/ready channel, which is always ready.
//   Write it only while no segment is in flight; the block does not check.
//   Throughput is one item per cycle while the receiver does not stall.
//   A result reaches the output register through one input register, a
//   stage holding the quotient of the length by one hundred, a stage
//   holding the check size, then the CRC and compare logic feeding the
//   result register. While the receiver stalls, the stages keep taking
//   items until all three hold one behind the waiting result; then input
//   ready falls.
//   Reset clears the pipeline, the running segment and the image size.
`timescale 1ns / 1ps

module segment_crc_compare_checker_top
    import scc_pkg::*;
#(
    parameter int MAX_CHECK_BYTES = 1048576
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    // Width of the byte counter: the cap, or the largest uncapped size.
    localparam int CAP_W = $clog2(MAX_CHECK_BYTES + 1);
    localparam int CNT_W = (CAP_W > FULL_W) ? CAP_W : FULL_W;

    // Configuration register.
    logic [31:0] r_image_size;

    // Stage one: input register.
    logic        r_s1_valid;
    t_in_item    r_s1_item;

    // Stage two: length quotient and length class.
    logic              r_s2_valid;
    logic              r_s2_op;
    logic [31:0]       r_s2_off;
    logic [FULL_W-1:0] r_s2_len_lo;
    logic [QUOT_W-1:0] r_s2_quot;
    logic              r_s2_full;
    logic              r_s2_half;
    logic [7:0]        r_s2_host;
    logic [7:0]        r_s2_dev;

    // Stage three: check size ready for the segment state.
    logic             r_s3_valid;
    logic             r_s3_op;
    logic [31:0]      r_s3_off;
    logic [CNT_W-1:0] r_s3_size;
    logic [7:0]       r_s3_host;
    logic [7:0]       r_s3_dev;

    // Segment state.
    logic             r_busy;
    logic [CNT_W-1:0] r_left;
    logic [31:0]      r_host_acc;
    logic [31:0]      r_dev_acc;
    logic             n_busy;
    logic [CNT_W-1:0] n_left;
    logic [31:0]      n_host_acc;
    logic [31:0]      n_dev_acc;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out_item;

    logic             out_free;
    logic             s3_ready;
    logic             s2_ready;
    logic             s1_ready;
    logic             s3_adv;
    logic [63:0]      quot_prod;
    logic [31:0]      quot_x25;
    logic [31:0]      quot_x50;
    logic [CNT_W-1:0] size_calc;
    logic [32:0]      seg_end;
    logic             over_range;
    logic [31:0]      host_next;
    logic [31:0]      dev_next;
    logic [31:0]      host_final;
    logic [31:0]      dev_final;
    logic             res_valid;
    t_out_item        res_item;

    // Ready ripples back through empty stages, so bubbles are absorbed during a stall.
    assign out_free    = !r_out_valid || i_out_ready;
    assign s3_ready    = !r_s3_valid || out_free;
    assign s2_ready    = !r_s2_valid || s3_ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign s3_adv      = r_s3_valid && out_free;
    assign o_in_ready  = s1_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Quotient of the length by one hundred through the reciprocal product.
    assign quot_prod = 64'(r_s1_item.seg_length) * 64'(DIV100_MUL);

    // Sampled size: full, half or a capped quarter of the whole hundreds.
    assign quot_x25 = (32'(r_s2_quot) << 4) + (32'(r_s2_quot) << 3) + 32'(r_s2_quot);
    assign quot_x50 = quot_x25 << 1;

    always_comb begin
        priority if (r_s2_full) begin
            size_calc = CNT_W'(r_s2_len_lo);
        end else if (r_s2_half) begin
            size_calc = CNT_W'(quot_x50);
        end else if (quot_x25 > 32'(MAX_CHECK_BYTES)) begin
            size_calc = CNT_W'(MAX_CHECK_BYTES);
        end else begin
            size_calc = CNT_W'(quot_x25);
        end
    end

    // Range test at full precision.
    assign seg_end    = {1'b0, r_s3_off} + 33'(r_s3_size);
    assign over_range = seg_end > {1'b0, r_image_size};

    // Byte updates of both running CRCs.
    scc_crc8 u_host_crc (
        .i_crc  (r_host_acc),
        .i_byte (r_s3_host),
        .o_crc  (host_next)
    );

    scc_crc8 u_dev_crc (
        .i_crc  (r_dev_acc),
        .i_byte (r_s3_dev),
        .o_crc  (dev_next)
    );

    assign host_final = ~host_next;
    assign dev_final  = ~dev_next;

    // Segment state update and result of the item in stage three.
    always_comb begin
        n_busy     = r_busy;
        n_left     = r_left;
        n_host_acc = r_host_acc;
        n_dev_acc  = r_dev_acc;
        res_valid  = 1'b0;
        res_item   = '0;
        if (r_s3_op == OP_BEGIN) begin
            n_busy     = 1'b0;
            n_left     = '0;
            n_host_acc = CRC_INIT;
            n_dev_acc  = CRC_INIT;
            priority if (over_range) begin
                res_valid       = 1'b1;
                res_item.status = STATUS_SKIPPED;
            end else if (r_s3_size == '0) begin
                res_valid       = 1'b1;
                res_item.status = STATUS_MATCH;
            end else begin
                n_busy = 1'b1;
                n_left = r_s3_size;
            end
        end else if (r_busy) begin
            n_host_acc = host_next;
            n_dev_acc  = dev_next;
            n_left     = r_left - CNT_W'(1);
            if (r_left == CNT_W'(1)) begin
                n_busy              = 1'b0;
                n_host_acc          = CRC_INIT;
                n_dev_acc           = CRC_INIT;
                res_valid           = 1'b1;
                res_item.host_crc   = host_final;
                res_item.device_crc = dev_final;
                priority if (dev_final == 32'd0) begin
                    res_item.status = STATUS_UNREAD;
                end else if (host_final == dev_final) begin
                    res_item.status = STATUS_MATCH;
                end else begin
                    res_item.status = STATUS_CORRUPTED;
                end
            end
        end
    end

    // Control state: stage valids, segment state, result valid, image size.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s3_valid   <= 1'b0;
            r_busy       <= 1'b0;
            r_left       <= '0;
            r_host_acc   <= CRC_INIT;
            r_dev_acc    <= CRC_INIT;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_image_size <= i_cfg_data;
            end
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
            if (s3_adv) begin
                r_busy     <= n_busy;
                r_left     <= n_left;
                r_host_acc <= n_host_acc;
                r_dev_acc  <= n_dev_acc;
            end
            if (s3_adv && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers of the stages and the result.
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1_item <= i_in_item;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_op     <= r_s1_item.operation;
            r_s2_off    <= r_s1_item.seg_offset;
            r_s2_len_lo <= r_s1_item.seg_length[FULL_W-1:0];
            r_s2_quot   <= quot_prod[63:DIV100_SHIFT];
            r_s2_full   <= r_s1_item.seg_length <= FULL_LIMIT;
            r_s2_half   <= r_s1_item.seg_length <= HALF_LIMIT;
            r_s2_host   <= r_s1_item.host_byte;
            r_s2_dev    <= r_s1_item.device_byte;
        end
        if (s3_ready && r_s2_valid) begin
            r_s3_op   <= r_s2_op;
            r_s3_off  <= r_s2_off;
            r_s3_size <= size_calc;
            r_s3_host <= r_s2_host;
            r_s3_dev  <= r_s2_dev;
        end
        if (s3_adv && res_valid) begin
            r_out_item <= res_item;
        end
    end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the segment CRC compare checker.
// Depends on scc_pkg and segment_crc_compare_checker_top, which in turn needs scc_crc8.
// It drives directed and random items and checks every verdict against its own predictor or the directed table.
`timescale 1ns / 1ps

module tb;
    import scc_pkg::*;

    localparam logic [31:0] MAX_CHECK  = 32'd1048576;
    localparam int          SETTLE     = 8;
    localparam int          WATCHDOG   = 400000;
    localparam int          HOLD_LEN   = 80;

    // Verdicts that can be read straight off the rules.
    localparam t_out_item NO_VERDICT    = '0;
    localparam t_out_item SKIP_VERDICT  = '{STATUS_SKIPPED, 32'd0, 32'd0};
    localparam t_out_item EMPTY_VERDICT = '{STATUS_MATCH, 32'd0, 32'd0};

    typedef enum logic [1:0] {ROW_CFG, ROW_BEGIN, ROW_PAIR, ROW_ZERO_TAIL} t_row_kind;

    // One directed step: a register write, a begin, a byte pair, or four pairs
    // whose device bytes drive the device CRC to zero.
    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] a;
        logic [31:0] b;
        logic        typed;
        t_out_item   verdict;
    } t_row;

    localparam int N_PLAN = 22;

    t_row plan [N_PLAN] = '{
        '{ROW_BEGIN, 32'h0000_0000, 32'h0000_0000, 1'b1, EMPTY_VERDICT},
        '{ROW_BEGIN, 32'h0000_0000, 32'h0000_0001, 1'b1, SKIP_VERDICT},
        '{ROW_PAIR,  32'h0000_00FF, 32'h0000_0000, 1'b0, NO_VERDICT},
        '{ROW_CFG,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, NO_VERDICT},
        '{ROW_BEGIN, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, EMPTY_VERDICT},
        '{ROW_BEGIN, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, SKIP_VERDICT},
        '{ROW_BEGIN, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, NO_VERDICT},
        '{ROW_BEGIN, 32'hFFF0_0000, 32'hFFFF_FFFF, 1'b1, SKIP_VERDICT},
        '{ROW_BEGIN, 32'hFFEF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_VERDICT},
        '{ROW_BEGIN, 32'hFFFC_0000, 32'h0004_0000, 1'b1, SKIP_VERDICT},
        '{ROW_BEGIN, 32'hFFFB_FFFF, 32'h0004_0000, 1'b0, NO_VERDICT},
        '{ROW_BEGIN, 32'hFFFE_0016, 32'h0004_0001, 1'b0, NO_VERDICT},
        '{ROW_BEGIN, 32'hFFFF_FFFF, 32'h0010_0000, 1'b1, SKIP_VERDICT},
        '{ROW_BEGIN, 32'h0000_0000, 32'h0000_0002, 1'b0, NO_VERDICT},
        '{ROW_PAIR,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_VERDICT},
        '{ROW_PAIR,  32'h0000_00FF, 32'h0000_00FF, 1'b0, NO_VERDICT},
        '{ROW_BEGIN, 32'h0000_0010, 32'h0000_0002, 1'b0, NO_VERDICT},
        '{ROW_PAIR,  32'h0000_0012, 32'h0000_0013, 1'b0, NO_VERDICT},
        '{ROW_PAIR,  32'h0000_00FF, 32'h0000_0000, 1'b0, NO_VERDICT},
        '{ROW_BEGIN, 32'h0000_0000, 32'h0000_0005, 1'b0, NO_VERDICT},
        '{ROW_PAIR,  32'h0000_005A, 32'h0000_00C3, 1'b0, NO_VERDICT},
        '{ROW_ZERO_TAIL, 32'h0000_003C, 32'h0000_0000, 1'b0, NO_VERDICT}
    };

    // Signals towards the block, all known from time zero.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_item   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data  = '0;
    logic        in_ready;
    logic        out_valid;
    t_out_item   out_item;
    logic        cfg_ready;

    // Predictor state.
    logic [31:0] img_bound = '0;
    logic        seg_open  = 1'b0;
    logic [31:0] seg_left  = '0;
    logic [31:0] host_run  = CRC_INIT;
    logic [31:0] dev_run   = CRC_INIT;

    // Verdicts still owed by the block, oldest first.
    t_out_item   pending_verdicts [$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_req      = 1'b0;
    int          hold_left     = 0;
    int          errors        = 0;
    int          items_taken   = 0;
    int          cfg_writes    = 0;
    int          cycles        = 0;
    int          verdicts_seen [4] = '{0, 0, 0, 0};

    segment_crc_compare_checker_top #(
        .MAX_CHECK_BYTES(MAX_CHECK)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // Clock with a 12 ns period.
    initial begin
        forever #6 clk = ~clk;
    end

    // Sampled check size derived from a segment length.
    function automatic logic [31:0] sampled_size(input logic [31:0] len);
        logic [31:0] s;
        if (len <= FULL_LIMIT) begin
            return len;
        end
        if (len <= HALF_LIMIT) begin
            return (len / 32'd100) * 32'd50;
        end
        s = (len / 32'd100) * 32'd25;
        return (s > MAX_CHECK) ? MAX_CHECK : s;
    endfunction

    // One byte folded into a reflected CRC-32 register.
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Four bytes, lowest first, that bring the register from acc to all ones,
    // so that the inverted device CRC comes out as zero. The shift steps are
    // run backwards from the target; the feedback shows in the top bit.
    function automatic logic [31:0] zero_tail(input logic [31:0] acc);
        logic [31:0] c;
        c = CRC_INIT;
        for (int k = 0; k < 32; k++) begin
            c = c[31] ? (((c ^ CRC_POLY) << 1) | 32'd1) : (c << 1);
        end
        return c ^ acc;
    endfunction

    // Predicts the block's response to one accepted item.
    task automatic predict_verdict(input t_in_item it, output bit gives, output bit taken,
                                   output t_out_item res);
        logic [31:0] sz;
        logic [31:0] h;
        logic [31:0] d;
        gives = 1'b0;
        taken = 1'b1;
        res   = '0;
        if (it.operation == OP_BEGIN) begin
            sz       = sampled_size(it.seg_length);
            seg_open = 1'b0;
            seg_left = '0;
            host_run = CRC_INIT;
            dev_run  = CRC_INIT;
            if ({1'b0, it.seg_offset} + {1'b0, sz} > {1'b0, img_bound}) begin
                gives      = 1'b1;
                res.status = STATUS_SKIPPED;
            end else if (sz == 32'd0) begin
                gives      = 1'b1;
                res.status = STATUS_MATCH;
            end else begin
                seg_open = 1'b1;
                seg_left = sz;
            end
        end else if (!seg_open) begin
            taken = 1'b0;
        end else begin
            host_run = crc_fold(host_run, it.host_byte);
            dev_run  = crc_fold(dev_run, it.device_byte);
            seg_left = seg_left - 32'd1;
            if (seg_left == 32'd0) begin
                h              = ~host_run;
                d              = ~dev_run;
                gives          = 1'b1;
                res.host_crc   = h;
                res.device_crc = d;
                if (d == 32'd0) begin
                    res.status = STATUS_UNREAD;
                end else if (h == d) begin
                    res.status = STATUS_MATCH;
                end else begin
                    res.status = STATUS_CORRUPTED;
                end
                seg_open = 1'b0;
                host_run = CRC_INIT;
                dev_run  = CRC_INIT;
            end
        end
    endtask

    // Offers one item, waits for it to be taken, and records what it should cause.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        bit        gives;
        bit        taken;
        t_out_item res;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        predict_verdict(it, gives, taken, res);
        if (typed) begin
            gives = 1'b1;
            res   = typed_res;
        end
        if (gives) begin
            pending_verdicts.push_back(res);
        end
        if (taken) begin
            items_taken++;
        end
    endtask

    // Writes the image size once the block has nothing left in flight.
    task automatic write_image_size(input logic [31:0] value);
        t_in_item it;
        if (seg_open) begin
            // A begin past the end of any image closes the running segment.
            it            = '0;
            it.operation  = OP_BEGIN;
            it.seg_offset = 32'hFFFF_FFFF;
            it.seg_length = 32'd1;
            send_item(it, 1'b0, NO_VERDICT);
        end
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        img_bound = value;
        cfg_writes++;
    endtask

    // One random stretch: mostly whole segments with random bytes, the rest
    // wild begins, begins on the range boundary, empty begins and stray pairs.
    task automatic random_burst();
        int          pick;
        int          n;
        logic [31:0] len;
        logic [31:0] sz;
        logic [31:0] off;
        logic [31:0] tail;
        logic [7:0]  h;
        logic [7:0]  d;
        bit          same;
        bit          zero_end;
        t_in_item    it;
        pick = $urandom_range(99);
        it   = '0;
        if (pick < 65) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
            off = (img_bound >= len) ? $urandom_range(img_bound - len) : $urandom;
            it.operation  = OP_BEGIN;
            it.seg_offset = off;
            it.seg_length = len;
            send_item(it, 1'b0, NO_VERDICT);
            // Now and then the segment is cut short and abandoned by the next begin.
            n        = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : len;
            zero_end = (n == len) && (len >= 4) && ($urandom_range(3) == 0);
            same     = $urandom_range(1);
            tail     = '0;
            for (int k = 0; k < n; k++) begin
                h = 8'($urandom);
                if (same) begin
                    d = h;
                end else if ($urandom_range(1) == 1) begin
                    d = h ^ (8'd1 << $urandom_range(7));
                end else begin
                    d = 8'($urandom);
                end
                if (zero_end && k == len - 4) begin
                    tail = zero_tail(dev_run);
                end
                if (zero_end && k >= len - 4) begin
                    d = tail[8 * (k - (len - 4)) +: 8];
                end
                it             = '0;
                it.operation   = OP_PAIR;
                it.host_byte   = h;
                it.device_byte = d;
                send_item(it, 1'b0, NO_VERDICT);
            end
        end else if (pick < 75) begin
            it.operation  = OP_BEGIN;
            it.seg_offset = $urandom;
            it.seg_length = $urandom;
            send_item(it, 1'b0, NO_VERDICT);
        end else if (pick < 85) begin
            // Offset set right at, or one past, the last in-range place.
            case ($urandom_range(2))
                0: begin
                    len = $urandom_range(32'd262144, 32'd1);
                end
                1: begin
                    len = $urandom_range(32'd1048576, 32'd262145);
                end
                default: begin
                    len = $urandom_range(32'hFFFF_FFFF, 32'd1048577);
                end
            endcase
            sz = sampled_size(len);
            it.operation  = OP_BEGIN;
            it.seg_offset = (img_bound >= sz) ? img_bound - sz + $urandom_range(1) : $urandom;
            it.seg_length = len;
            send_item(it, 1'b0, NO_VERDICT);
        end else if (pick < 93) begin
            it.operation  = OP_BEGIN;
            it.seg_offset = ($urandom_range(3) == 0) ? $urandom : $urandom_range(img_bound);
            it.seg_length = '0;
            send_item(it, 1'b0, NO_VERDICT);
        end else begin
            repeat ($urandom_range(3, 1)) begin
                it             = '0;
                it.operation   = OP_PAIR;
                it.host_byte   = 8'($urandom);
                it.device_byte = 8'($urandom);
                send_item(it, 1'b0, NO_VERDICT);
            end
        end
    endtask

    // One phase of random traffic under one image size and one idling pattern.
    task automatic run_phase(input int s_idle, input int r_idle, input logic [31:0] img,
                             input int n_items, input bit squeeze);
        int       goal;
        t_in_item it;
        write_image_size(img);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        goal          = items_taken + n_items;
        if (squeeze) begin
            // The receiver holds off while every item asks for a verdict,
            // so the pipeline fills and input ready has to fall.
            hold_req = 1'b1;
            for (int k = 0; k < 24; k++) begin
                it           = '0;
                it.operation = OP_BEGIN;
                if ($urandom_range(1) == 1) begin
                    it.seg_offset = $urandom_range(img_bound);
                end else begin
                    it.seg_offset = 32'hFFFF_FFFF;
                    it.seg_length = $urandom_range(100, 1);
                end
                send_item(it, 1'b0, NO_VERDICT);
            end
        end
        while (items_taken < goal) begin
            random_burst();
        end
    endtask

    // Receiver: random stalls, plus one long hold counted here when asked for.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Verdict checker: each accepted verdict against the oldest one owed.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            verdicts_seen[out_item.status]++;
            if (pending_verdicts.size() == 0) begin
                errors++;
                $display("%0t: unexpected verdict status %0d host %h device %h", $time,
                         out_item.status, out_item.host_crc, out_item.device_crc);
            end else begin
                want = pending_verdicts.pop_front();
                if (want != out_item) begin
                    errors++;
                    $display("%0t: mismatch: expected %0d %h %h, got %0d %h %h",
                             $time, want.status, want.host_crc, want.device_crc,
                             out_item.status, out_item.host_crc, out_item.device_crc);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles++;
        if (cycles > WATCHDOG) begin
            $display("%0t: run timed out after %0d cycles", $time, cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then four random phases.
    initial begin
        t_in_item    it;
        logic [31:0] tail;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 24;
        recv_idle_pct = 69;
        for (int r = 0; r < N_PLAN; r++) begin
            it = '0;
            case (plan[r].kind)
                ROW_CFG: begin
                    write_image_size(plan[r].a);
                end
                ROW_BEGIN: begin
                    it.operation  = OP_BEGIN;
                    it.seg_offset = plan[r].a;
                    it.seg_length = plan[r].b;
                    send_item(it, plan[r].typed, plan[r].verdict);
                end
                ROW_PAIR: begin
                    it.operation   = OP_PAIR;
                    it.host_byte   = plan[r].a[7:0];
                    it.device_byte = plan[r].b[7:0];
                    send_item(it, plan[r].typed, plan[r].verdict);
                end
                default: begin
                    tail = zero_tail(dev_run);
                    for (int j = 0; j < 4; j++) begin
                        it             = '0;
                        it.operation   = OP_PAIR;
                        it.host_byte   = plan[r].a[7:0];
                        it.device_byte = tail[8 * j +: 8];
                        send_item(it, 1'b0, NO_VERDICT);
                    end
                end
            endcase
        end

        run_phase(24, 69, 32'hFFFF_FFFF, 200, 1'b0);
        run_phase(69, 24, $urandom, 200, 1'b0);
        run_phase(0, 0, $urandom_range(64), 200, 1'b0);
        run_phase(0, 0, 32'hFFFF_FFFF, 200, 1'b1);

        // Drain: every owed verdict, then a quiet wait for stray verdicts.
        in_valid <= 1'b0;
        recv_idle_pct = 0;
        while (pending_verdicts.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);

        $display("Run covered %0d items and %0d image size writes in %0d cycles.",
                 items_taken, cfg_writes, cycles);
        $display("Verdicts seen: match %0d, corrupted %0d, skipped %0d, unread %0d; %0d errors.",
                 verdicts_seen[STATUS_MATCH], verdicts_seen[STATUS_CORRUPTED],
                 verdicts_seen[STATUS_SKIPPED], verdicts_seen[STATUS_UNREAD], errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
